FILE: rtl/core/csm_pkg.sv
`timescale 1ns / 1ps

package csm_pkg;

    // defaults for the top-level parameters
    localparam int MAX_STRING_DEPTH_DEF = 255;
    localparam int MAX_HELD_ZEROS_DEF   = 60;

    // held-zero run fits 0..60
    localparam int ZCNT_W    = 6;
    // literal bytes one input byte can produce besides a zero run
    localparam int LIT_SLOTS = 4;
    localparam int LIT_CNT_W = $clog2(LIT_SLOTS + 1);
    // dot + zero run + literals
    localparam int RUN_W     = $clog2(1 + (1 << ZCNT_W) + LIT_SLOTS);
    localparam int CMD_QUEUE_DEPTH = 4;

    localparam logic [7:0] C_NUL    = 8'h00;
    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_LF     = 8'h0A;
    localparam logic [7:0] C_VT     = 8'h0B;
    localparam logic [7:0] C_FF     = 8'h0C;
    localparam logic [7:0] C_CR     = 8'h0D;
    localparam logic [7:0] C_SP     = 8'h20;
    localparam logic [7:0] C_PCT    = 8'h25;
    localparam logic [7:0] C_LPAR   = 8'h28;
    localparam logic [7:0] C_RPAR   = 8'h29;
    localparam logic [7:0] C_PLUS   = 8'h2B;
    localparam logic [7:0] C_MINUS  = 8'h2D;
    localparam logic [7:0] C_DOT    = 8'h2E;
    localparam logic [7:0] C_SLASH  = 8'h2F;
    localparam logic [7:0] C_ZERO   = 8'h30;
    localparam logic [7:0] C_NINE   = 8'h39;
    localparam logic [7:0] C_LT     = 8'h3C;
    localparam logic [7:0] C_GT     = 8'h3E;
    localparam logic [7:0] C_LBRK   = 8'h5B;
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_RBRK   = 8'h5D;

    // output run for one input byte: optional dot, zero run, then literals
    typedef struct packed {
        logic [LIT_SLOTS-1:0][7:0] lit;
        logic [LIT_CNT_W-1:0]      lit_cnt;
        logic                      dot;
        logic [ZCNT_W-1:0]         zeros;
        logic                      eos;
    } t_cmd;

endpackage

FILE: rtl/core/csm_in_if.sv
`timescale 1ns / 1ps

interface csm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

FILE: rtl/core/csm_out_if.sv
`timescale 1ns / 1ps

interface csm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       stream_end;

    modport source (output valid, output out_byte, output byte_valid,
                    output last_of_run, output stream_end, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input last_of_run, input stream_end, output ready);
endinterface

FILE: rtl/core/csm_front.sv
`timescale 1ns / 1ps

module csm_front #(
    parameter int MAX_STRING_DEPTH = csm_pkg::MAX_STRING_DEPTH_DEF,
    parameter int MAX_HELD_ZEROS   = csm_pkg::MAX_HELD_ZEROS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    csm_in_if.sink        i_in,
    input  logic          i_full,
    output logic          o_push,
    output csm_pkg::t_cmd o_cmd
);
    import csm_pkg::*;

    localparam int DEPTH_W   = $clog2(MAX_STRING_DEPTH + 1);
    localparam int LIT_IDX_W = $clog2(LIT_SLOTS);

    typedef enum logic [2:0] {
        M_IDLE, M_COMMENT, M_STRING, M_HEX, M_NAME, M_WORD, M_NUM, M_NUMSIGN
    } t_mode;

    typedef enum logic [1:0] {A_NONE, A_LT, A_GT} t_angle;

    t_mode              r_mode, n_mode;
    t_angle             r_angle, n_angle;
    logic               r_sep, n_sep;
    logic               r_started, n_started;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic               r_esc, n_esc;
    logic               r_lzh, n_lzh;
    logic               r_ids, n_ids;
    logic               r_dseen, n_dseen;
    logic               r_dheld, n_dheld;
    logic [ZCNT_W-1:0]  r_zcnt, n_zcnt;

    logic accept;

    function automatic logic is_ws(input logic [7:0] c);
        return c == C_SP || c == C_TAB || c == C_CR || c == C_LF || c == C_VT || c == C_FF;
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return is_ws(c) || c == C_SLASH || c == C_LBRK || c == C_RBRK || c == C_LT ||
               c == C_GT || c == C_LPAR || c == C_RPAR;
    endfunction

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign o_push     = accept;

    always_comb begin
        logic [7:0]           c;
        logic                 consumed;
        logic                 do_idle;
        logic [LIT_CNT_W-1:0] cnt;
        logic                 tok;

        c        = i_in.in_byte;
        consumed = 1'b0;
        do_idle  = 1'b0;
        cnt      = '0;
        tok      = 1'b0;

        n_mode    = r_mode;
        n_angle   = r_angle;
        n_sep     = r_sep;
        n_started = r_started;
        n_depth   = r_depth;
        n_esc     = r_esc;
        n_lzh     = r_lzh;
        n_ids     = r_ids;
        n_dseen   = r_dseen;
        n_dheld   = r_dheld;
        n_zcnt    = r_zcnt;

        o_cmd     = '0;
        o_cmd.eos = i_in.end_of_stream;

        // pending angle from the previous byte decides << / >> / hex open
        if (r_angle == A_LT) begin
            n_angle = A_NONE;
            if (n_sep) begin
                o_cmd.lit[cnt[LIT_IDX_W-1:0]] = C_LF; cnt = cnt + 1'b1;
                n_sep = 1'b0;
            end
            o_cmd.lit[cnt[LIT_IDX_W-1:0]] = C_LT; cnt = cnt + 1'b1;
            n_started = 1'b1;
            if (c == C_LT) begin
                o_cmd.lit[cnt[LIT_IDX_W-1:0]] = C_LT; cnt = cnt + 1'b1;
                consumed = 1'b1;
            end else begin
                n_mode = M_HEX;
            end
        end else if (r_angle == A_GT) begin
            n_angle = A_NONE;
            o_cmd.lit[cnt[LIT_IDX_W-1:0]] = C_GT; cnt = cnt + 1'b1;
            n_started = 1'b1;
            n_sep = 1'b1;
            if (c == C_GT) begin
                o_cmd.lit[cnt[LIT_IDX_W-1:0]] = C_GT; cnt = cnt + 1'b1;
                consumed = 1'b1;
            end
        end

        if (!consumed) begin
            case (n_mode)
                M_IDLE: begin
                    do_idle = 1'b1;
                end
                M_COMMENT: begin
                    if (c == C_LF) begin
                        n_mode  = M_IDLE;
                        do_idle = 1'b1;
                    end
                end
                M_STRING: begin
                    o_cmd.lit[cnt[LIT_IDX_W-1:0]] = c; cnt = cnt + 1'b1;
                    n_started = 1'b1;
                    if (n_esc) begin
                        n_esc = 1'b0;
                    end else if (c == C_BSLASH) begin
                        n_esc = 1'b1;
                    end else if (c == C_LPAR) begin
                        if (n_depth < DEPTH_W'(MAX_STRING_DEPTH))
                            n_depth = n_depth + 1'b1;
                    end else if (c == C_RPAR) begin
                        if (n_depth != '0)
                            n_depth = n_depth - 1'b1;
                        if (n_depth == '0) begin
                            n_mode = M_IDLE;
                            n_sep  = 1'b1;
                        end
                    end
                end
                M_HEX: begin
                    if (c == C_GT) begin
                        o_cmd.lit[cnt[LIT_IDX_W-1:0]] = C_GT; cnt = cnt + 1'b1;
                        n_started = 1'b1;
                        n_mode = M_IDLE;
                        n_sep  = 1'b1;
                    end else if (!is_ws(c)) begin
                        o_cmd.lit[cnt[LIT_IDX_W-1:0]] = c; cnt = cnt + 1'b1;
                        n_started = 1'b1;
                    end
                end
                M_NAME, M_WORD, M_NUM, M_NUMSIGN: begin
                    if (is_delim(c)) begin
                        // close the token, then treat the delimiter as a fresh byte
                        if ((n_mode == M_NUM || n_mode == M_NUMSIGN) &&
                            (n_lzh || (n_dheld && !n_ids))) begin
                            o_cmd.lit[cnt[LIT_IDX_W-1:0]] = C_ZERO; cnt = cnt + 1'b1;
                            n_started = 1'b1;
                        end
                        n_lzh   = 1'b0;
                        n_ids   = 1'b0;
                        n_dseen = 1'b0;
                        n_dheld = 1'b0;
                        n_zcnt  = '0;
                        n_sep   = 1'b1;
                        n_mode  = M_IDLE;
                        do_idle = 1'b1;
                    end else if (n_mode == M_NAME || n_mode == M_WORD) begin
                        o_cmd.lit[cnt[LIT_IDX_W-1:0]] = c; cnt = cnt + 1'b1;
                        n_started = 1'b1;
                    end else if (n_mode == M_NUMSIGN && c == C_ZERO) begin
                        n_mode = M_NUM;
                        n_lzh  = 1'b1;
                    end else begin
                        n_mode = M_NUM;
                        if (n_dseen) begin
                            // fraction: zeros held until a nonzero digit or the cap
                            if (c == C_ZERO && n_zcnt < ZCNT_W'(MAX_HELD_ZEROS)) begin
                                n_zcnt = n_zcnt + 1'b1;
                            end else begin
                                n_lzh       = 1'b0;
                                o_cmd.dot   = n_dheld;
                                n_dheld     = 1'b0;
                                o_cmd.zeros = n_zcnt;
                                n_zcnt      = '0;
                                o_cmd.lit[cnt[LIT_IDX_W-1:0]] = c; cnt = cnt + 1'b1;
                                n_started = 1'b1;
                            end
                        end else begin
                            if (n_lzh && c != C_DOT) begin
                                o_cmd.lit[cnt[LIT_IDX_W-1:0]] = C_ZERO; cnt = cnt + 1'b1;
                                n_started = 1'b1;
                                n_lzh = 1'b0;
                                n_ids = 1'b1;
                            end
                            if (c == C_DOT) begin
                                n_dseen = 1'b1;
                                n_dheld = 1'b1;
                            end else begin
                                o_cmd.lit[cnt[LIT_IDX_W-1:0]] = c; cnt = cnt + 1'b1;
                                n_started = 1'b1;
                                n_ids = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    n_mode  = M_IDLE;
                    do_idle = 1'b1;
                end
            endcase
        end

        if (do_idle) begin
            if (is_ws(c)) begin
                if (n_started)
                    n_sep = 1'b1;
            end else if (c == C_PCT) begin
                n_mode = M_COMMENT;
            end else if (c == C_RPAR || c == C_RBRK) begin
                // lone closer: no newline before it
                o_cmd.lit[cnt[LIT_IDX_W-1:0]] = c; cnt = cnt + 1'b1;
                n_started = 1'b1;
                n_sep = 1'b1;
            end else if (c == C_LT) begin
                n_angle = A_LT;
            end else if (c == C_GT) begin
                n_angle = A_GT;
            end else begin
                if (n_sep) begin
                    o_cmd.lit[cnt[LIT_IDX_W-1:0]] = C_LF; cnt = cnt + 1'b1;
                    n_started = 1'b1;
                    n_sep = 1'b0;
                end
                if (c == C_LPAR) begin
                    o_cmd.lit[cnt[LIT_IDX_W-1:0]] = c; cnt = cnt + 1'b1;
                    n_started = 1'b1;
                    n_depth = DEPTH_W'(1);
                    n_esc   = 1'b0;
                    n_mode  = M_STRING;
                end else if (c == C_LBRK) begin
                    o_cmd.lit[cnt[LIT_IDX_W-1:0]] = c; cnt = cnt + 1'b1;
                    n_started = 1'b1;
                end else if (c == C_SLASH) begin
                    o_cmd.lit[cnt[LIT_IDX_W-1:0]] = c; cnt = cnt + 1'b1;
                    n_started = 1'b1;
                    n_mode = M_NAME;
                end else if (c == C_MINUS) begin
                    o_cmd.lit[cnt[LIT_IDX_W-1:0]] = c; cnt = cnt + 1'b1;
                    n_started = 1'b1;
                    n_mode = M_NUMSIGN;
                end else if (c == C_ZERO) begin
                    n_mode = M_NUM;
                    n_lzh  = 1'b1;
                end else if (c == C_DOT) begin
                    n_mode  = M_NUM;
                    n_dseen = 1'b1;
                    n_dheld = 1'b1;
                end else if (c == C_PLUS || (c > C_ZERO && c <= C_NINE)) begin
                    o_cmd.lit[cnt[LIT_IDX_W-1:0]] = c; cnt = cnt + 1'b1;
                    n_started = 1'b1;
                    n_mode = M_NUM;
                    n_ids  = (c != C_PLUS);
                end else begin
                    o_cmd.lit[cnt[LIT_IDX_W-1:0]] = c; cnt = cnt + 1'b1;
                    n_started = 1'b1;
                    n_mode = M_WORD;
                end
            end
        end

        if (i_in.end_of_stream) begin
            if (n_angle == A_LT) begin
                if (n_sep) begin
                    o_cmd.lit[cnt[LIT_IDX_W-1:0]] = C_LF; cnt = cnt + 1'b1;
                end
                o_cmd.lit[cnt[LIT_IDX_W-1:0]] = C_LT; cnt = cnt + 1'b1;
            end else if (n_angle == A_GT) begin
                o_cmd.lit[cnt[LIT_IDX_W-1:0]] = C_GT; cnt = cnt + 1'b1;
            end
            tok = (n_mode == M_NUM || n_mode == M_NUMSIGN);
            if (tok && (n_lzh || (n_dheld && !n_ids))) begin
                o_cmd.lit[cnt[LIT_IDX_W-1:0]] = C_ZERO; cnt = cnt + 1'b1;
            end
            n_mode    = M_IDLE;
            n_angle   = A_NONE;
            n_sep     = 1'b0;
            n_started = 1'b0;
            n_depth   = '0;
            n_esc     = 1'b0;
            n_lzh     = 1'b0;
            n_ids     = 1'b0;
            n_dseen   = 1'b0;
            n_dheld   = 1'b0;
            n_zcnt    = '0;
        end

        o_cmd.lit_cnt = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_IDLE;
            r_angle   <= A_NONE;
            r_sep     <= 1'b0;
            r_started <= 1'b0;
            r_depth   <= '0;
            r_esc     <= 1'b0;
            r_lzh     <= 1'b0;
            r_ids     <= 1'b0;
            r_dseen   <= 1'b0;
            r_dheld   <= 1'b0;
            r_zcnt    <= '0;
        end else if (accept) begin
            r_mode    <= n_mode;
            r_angle   <= n_angle;
            r_sep     <= n_sep;
            r_started <= n_started;
            r_depth   <= n_depth;
            r_esc     <= n_esc;
            r_lzh     <= n_lzh;
            r_ids     <= n_ids;
            r_dseen   <= n_dseen;
            r_dheld   <= n_dheld;
            r_zcnt    <= n_zcnt;
        end
    end

endmodule

FILE: rtl/core/csm_queue.sv
`timescale 1ns / 1ps

module csm_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  csm_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output csm_pkg::t_cmd o_data,
    output logic          o_empty
);
    import csm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push)
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        if (do_pop)
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        if (do_push && !do_pop)
            n_cnt = r_cnt + 1'b1;
        else if (do_pop && !do_push)
            n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (do_push)
            r_mem[r_wr] <= i_data;
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: rtl/core/csm_back.sv
`timescale 1ns / 1ps

module csm_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  csm_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    csm_out_if.source     o_out
);
    import csm_pkg::*;

    logic [RUN_W-1:0] r_idx, n_idx;
    logic             r_valid;
    logic [7:0]       r_byte;
    logic             r_bv, r_last, r_end;

    logic             load, step, run_last;
    logic [RUN_W-1:0] total, zero_end, lit_pos;
    logic [7:0]       cur_byte;

    assign load     = !r_valid || o_out.ready;
    assign step     = load && !i_empty;
    assign zero_end = RUN_W'(i_cmd.dot) + RUN_W'(i_cmd.zeros);
    assign total    = zero_end + RUN_W'(i_cmd.lit_cnt);
    assign lit_pos  = r_idx - zero_end;
    assign run_last = (total == '0) || (r_idx == total - 1'b1);
    assign o_pop    = step && run_last;
    assign n_idx    = run_last ? '0 : r_idx + 1'b1;

    always_comb begin
        if (total == '0)
            cur_byte = C_NUL;
        else if (r_idx < RUN_W'(i_cmd.dot))
            cur_byte = C_DOT;
        else if (r_idx < zero_end)
            cur_byte = C_ZERO;
        else
            cur_byte = i_cmd.lit[lit_pos[$clog2(LIT_SLOTS)-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else if (step) begin
            r_idx   <= n_idx;
            r_valid <= 1'b1;
        end else if (load) begin
            r_valid <= 1'b0;
        end
        if (step) begin
            r_byte <= cur_byte;
            r_bv   <= (total != '0);
            r_last <= run_last;
            r_end  <= run_last && i_cmd.eos;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.out_byte    = r_byte;
    assign o_out.byte_valid  = r_bv;
    assign o_out.last_of_run = r_last;
    assign o_out.stream_end  = r_end;

endmodule

FILE: rtl/core/content_stream_minifier.sv
`timescale 1ns / 1ps

// Content stream minifier.
// i_in takes one raw byte per word with end_of_stream marking the last byte
// of a stream; o_out returns the minified bytes, one per word. Each input
// byte produces a run of one or more output words; last_of_run flags the
// final word of a run and stream_end the final word of a stream. A run with
// no real byte is a single word with byte_valid low.
// Front end lexes one byte per cycle unless the queue is full and writes a
// run descriptor into a four-entry queue; the back end expands descriptors at
// one word per cycle unless the receiver stalls. A byte reaches o_out through
// the queue and the output register. With one-word runs and a ready receiver,
// one input byte is taken per cycle; a longer run holds the back end until
// its last word is taken (62 words at most, only on a held-zero flush).
// If the receiver stalls, the output register holds its word and the queue
// fills; i_in.ready drops only when the queue is full.
// Reset (synchronous, active low) empties the queue and the output register
// and returns the lexer to idle between tokens.
module content_stream_minifier #(
    parameter int MAX_STRING_DEPTH = csm_pkg::MAX_STRING_DEPTH_DEF,
    parameter int MAX_HELD_ZEROS   = csm_pkg::MAX_HELD_ZEROS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    csm_in_if.sink    i_in,
    csm_out_if.source o_out
);
    import csm_pkg::*;

    t_cmd front_cmd, head_cmd;
    logic push, full, pop, empty;

    csm_front #(
        .MAX_STRING_DEPTH (MAX_STRING_DEPTH),
        .MAX_HELD_ZEROS   (MAX_HELD_ZEROS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    csm_queue #(
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_cmd),
        .o_empty (empty)
    );

    csm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (head_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

FILE: rtl/core/csm_checker.sv
`timescale 1ns / 1ps

module csm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_byte_valid,
    input logic       i_last_of_run,
    input logic       i_stream_end
);

    // output register is empty right after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_stream_end |-> i_last_of_run)
        else $error("stream end not on last word of run");

    // marker words stand alone and carry a zero byte
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_byte_valid |-> i_last_of_run && i_out_byte == 8'h00)
        else $error("malformed marker word");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte))
        else $error("output word changed while stalled");

endmodule

bind content_stream_minifier csm_checker u_csm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_byte    (o_out.out_byte),
    .i_byte_valid  (o_out.byte_valid),
    .i_last_of_run (o_out.last_of_run),
    .i_stream_end  (o_out.stream_end)
);

FILE: tb/tb_content_stream_minifier.sv
`timescale 1ns / 1ps

module tb_content_stream_minifier;
    import csm_pkg::*;

    localparam int MAX_DEPTH      = MAX_STRING_DEPTH_DEF;
    localparam int MAX_ZEROS      = MAX_HELD_ZEROS_DEF;
    localparam int MAX_RUN        = 64;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int IDLE_LIMIT     = 2000;
    localparam int TAIL_CYCLES    = 20;
    localparam int PHASE_ITEMS    = 55;
    localparam int HOLD_NEST      = 12;

    localparam logic [7:0] CH_A  = "a";
    localparam logic [7:0] CH_UA = "A";
    localparam logic [7:0] CH_STAR = "*";

    typedef enum logic [3:0] {
        LX_IDLE, LX_COMMENT, LX_STRING, LX_HEX, LX_NAME, LX_WORD, LX_NUM, LX_NUMSIGN
    } t_lex_mode;

    typedef enum logic [1:0] {ANG_NONE, ANG_LT, ANG_GT} t_angle;

    typedef struct packed {
        logic [7:0] data;
        logic       is_byte;
        logic       run_last;
        logic       strm_end;
    } t_mini_word;

    typedef struct packed {
        logic [7:0] chr;
        logic       eos;
        logic       typed;
        logic [7:0] exp_byte;
        logic       exp_valid;
    } t_dir_row;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    csm_in_if  in_if ();
    csm_out_if out_if ();

    content_stream_minifier i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #10 clk = ~clk;

    // lexer state of the predictor
    t_lex_mode lex_mode;
    t_angle    angle_wait;
    logic      need_newline;
    logic      emitted_any;
    int        paren_depth;
    logic      escape_next;
    logic      lead_zero_held;
    logic      int_digit_seen;
    logic      frac_dot_seen;
    logic      frac_dot_held;
    int        zero_run;

    t_mini_word minified_run[$];
    t_mini_word expected_words[$];
    logic [7:0] stream_bytes[$];

    int  mismatch_cnt = 0;
    int  tx_idle_pct  = 0;
    int  rx_stall_pct = 0;
    int  idle_cycles  = 0;
    bit  rx_hold_req  = 1'b0;
    bit  rx_hold_seen = 1'b0;
    int  rx_hold_left = 0;

    // short directed stream; rows with typed=1 carry their one-word result
    t_dir_row dir_rows [0:25] = '{
        '{C_SP,     1'b0, 1'b1, 8'h00,  1'b0},  // blank before any output
        '{C_NUL,    1'b0, 1'b1, C_NUL,  1'b1},
        '{8'hFF,    1'b1, 1'b1, 8'hFF,  1'b1},
        '{C_VT,     1'b0, 1'b1, 8'h00,  1'b0},
        '{C_RPAR,   1'b0, 1'b1, C_RPAR, 1'b1},  // lone close paren
        '{C_PCT,    1'b0, 1'b1, 8'h00,  1'b0},
        '{C_FF,     1'b0, 1'b1, 8'h00,  1'b0},
        '{C_LF,     1'b0, 1'b1, 8'h00,  1'b0},
        '{C_LPAR,   1'b0, 1'b0, 8'h00,  1'b0},
        '{C_BSLASH, 1'b0, 1'b0, 8'h00,  1'b0},
        '{C_LPAR,   1'b0, 1'b0, 8'h00,  1'b0},
        '{C_LPAR,   1'b0, 1'b0, 8'h00,  1'b0},
        '{C_RPAR,   1'b0, 1'b0, 8'h00,  1'b0},
        '{C_RPAR,   1'b0, 1'b0, 8'h00,  1'b0},
        '{C_GT,     1'b0, 1'b1, 8'h00,  1'b0},
        '{C_LT,     1'b0, 1'b0, 8'h00,  1'b0},  // lone '>' then '<'
        '{C_LT,     1'b0, 1'b0, 8'h00,  1'b0},
        '{C_DOT,    1'b0, 1'b0, 8'h00,  1'b0},  // bare fraction
        '{C_ZERO,   1'b0, 1'b0, 8'h00,  1'b0},
        '{C_RBRK,   1'b0, 1'b0, 8'h00,  1'b0},
        '{C_PLUS,   1'b0, 1'b0, 8'h00,  1'b0},  // plus keeps its zero
        '{C_ZERO,   1'b0, 1'b0, 8'h00,  1'b0},
        '{C_DOT,    1'b0, 1'b0, 8'h00,  1'b0},
        '{"5",      1'b0, 1'b0, 8'h00,  1'b0},
        '{C_ZERO,   1'b0, 1'b0, 8'h00,  1'b0},
        '{C_LT,     1'b1, 1'b0, 8'h00,  1'b0}   // trailing '<' at stream end
    };

    function automatic bit is_space(logic [7:0] c);
        return c inside {C_SP, C_TAB, C_CR, C_LF, C_VT, C_FF};
    endfunction

    function automatic bit is_delim(logic [7:0] c);
        return is_space(c) || (c inside {C_SLASH, C_LBRK, C_RBRK, C_LT, C_GT, C_LPAR, C_RPAR});
    endfunction

    function automatic void add_run_word(t_mini_word w);
        minified_run.insert(minified_run.size(), w);
    endfunction

    function automatic void add_expected(t_mini_word w);
        expected_words.insert(expected_words.size(), w);
    endfunction

    function automatic void add_stream_byte(logic [7:0] b);
        stream_bytes.insert(stream_bytes.size(), b);
    endfunction

    function automatic void reset_lexer();
        lex_mode       = LX_IDLE;
        angle_wait     = ANG_NONE;
        need_newline   = 1'b0;
        emitted_any    = 1'b0;
        paren_depth    = 0;
        escape_next    = 1'b0;
        lead_zero_held = 1'b0;
        int_digit_seen = 1'b0;
        frac_dot_seen  = 1'b0;
        frac_dot_held  = 1'b0;
        zero_run       = 0;
    endfunction

    function automatic void put_byte(logic [7:0] c);
        if (minified_run.size() < MAX_RUN)
            add_run_word(t_mini_word'{c, 1'b1, 1'b0, 1'b0});
        emitted_any = 1'b1;
    endfunction

    function automatic void put_newline();
        if (need_newline) begin
            put_byte(C_LF);
            need_newline = 1'b0;
        end
    endfunction

    function automatic void flush_fraction_run();
        lead_zero_held = 1'b0;
        if (frac_dot_held) begin
            put_byte(C_DOT);
            frac_dot_held = 1'b0;
        end
        repeat (zero_run) put_byte(C_ZERO);
        zero_run = 0;
    endfunction

    function automatic void number_digit(logic [7:0] c);
        if (frac_dot_seen) begin
            if (c == C_ZERO) begin
                if (zero_run >= MAX_ZEROS) begin
                    flush_fraction_run();
                    put_byte(C_ZERO);
                end else begin
                    zero_run++;
                end
            end else begin
                flush_fraction_run();
                put_byte(c);
            end
            return;
        end
        if (lead_zero_held) begin
            if (c == C_DOT) begin
                frac_dot_seen = 1'b1;
                frac_dot_held = 1'b1;
                return;
            end
            put_byte(C_ZERO);
            lead_zero_held = 1'b0;
            int_digit_seen = 1'b1;
        end
        if (c == C_DOT) begin
            frac_dot_seen = 1'b1;
            frac_dot_held = 1'b1;
        end else begin
            put_byte(c);
            int_digit_seen = 1'b1;
        end
    endfunction

    function automatic void close_token();
        if ((lex_mode inside {LX_NUM, LX_NUMSIGN}) &&
            (lead_zero_held || (frac_dot_held && !int_digit_seen)))
            put_byte(C_ZERO);
        lead_zero_held = 1'b0;
        int_digit_seen = 1'b0;
        frac_dot_seen  = 1'b0;
        frac_dot_held  = 1'b0;
        zero_run       = 0;
        need_newline   = 1'b1;
        lex_mode       = LX_IDLE;
    endfunction

    function automatic void idle_char(logic [7:0] c);
        if (is_space(c)) begin
            if (emitted_any)
                need_newline = 1'b1;
        end else if (c == C_PCT) begin
            lex_mode = LX_COMMENT;
        end else if (c == C_LPAR) begin
            put_newline();
            put_byte(C_LPAR);
            paren_depth = 1;
            escape_next = 1'b0;
            lex_mode = LX_STRING;
        end else if (c == C_RPAR || c == C_RBRK) begin
            put_byte(c);
            need_newline = 1'b1;
        end else if (c == C_LT) begin
            angle_wait = ANG_LT;
        end else if (c == C_GT) begin
            angle_wait = ANG_GT;
        end else if (c == C_LBRK) begin
            put_newline();
            put_byte(c);
        end else if (c == C_SLASH) begin
            put_newline();
            put_byte(c);
            lex_mode = LX_NAME;
        end else if (c == C_MINUS || c == C_PLUS || c == C_DOT ||
                     (c >= C_ZERO && c <= C_NINE)) begin
            put_newline();
            lex_mode = LX_NUM;
            if (c == C_MINUS) begin
                put_byte(c);
                lex_mode = LX_NUMSIGN;
            end else if (c == C_ZERO) begin
                lead_zero_held = 1'b1;
            end else if (c == C_DOT) begin
                frac_dot_seen = 1'b1;
                frac_dot_held = 1'b1;
            end else begin
                put_byte(c);
                int_digit_seen = (c != C_PLUS);
            end
        end else begin
            put_newline();
            put_byte(c);
            lex_mode = LX_WORD;
        end
    endfunction

    function automatic void mode_char(logic [7:0] c);
        case (lex_mode)
            LX_COMMENT: begin
                if (c == C_LF) begin
                    lex_mode = LX_IDLE;
                    idle_char(c);
                end
            end
            LX_STRING: begin
                put_byte(c);
                if (escape_next) begin
                    escape_next = 1'b0;
                end else if (c == C_BSLASH) begin
                    escape_next = 1'b1;
                end else if (c == C_LPAR) begin
                    if (paren_depth < MAX_DEPTH)
                        paren_depth++;
                end else if (c == C_RPAR) begin
                    if (paren_depth > 0)
                        paren_depth--;
                    if (paren_depth == 0) begin
                        lex_mode = LX_IDLE;
                        need_newline = 1'b1;
                    end
                end
            end
            LX_HEX: begin
                if (c == C_GT) begin
                    put_byte(C_GT);
                    lex_mode = LX_IDLE;
                    need_newline = 1'b1;
                end else if (!is_space(c)) begin
                    put_byte(c);
                end
            end
            LX_NAME, LX_WORD, LX_NUM, LX_NUMSIGN: begin
                if (is_delim(c)) begin
                    close_token();
                    idle_char(c);
                end else if (lex_mode == LX_NUMSIGN) begin
                    lex_mode = LX_NUM;
                    if (c == C_ZERO)
                        lead_zero_held = 1'b1;
                    else
                        number_digit(c);
                end else if (lex_mode == LX_NUM) begin
                    number_digit(c);
                end else begin
                    put_byte(c);
                end
            end
            default: idle_char(c);
        endcase
    endfunction

    // fills minified_run with the words that one input byte produces
    function automatic void predict_minified(logic [7:0] c, logic eos);
        bit taken;
        taken = 1'b0;
        minified_run.delete();
        if (angle_wait == ANG_LT) begin
            angle_wait = ANG_NONE;
            put_newline();
            put_byte(C_LT);
            if (c == C_LT) begin
                put_byte(C_LT);
                taken = 1'b1;
            end else begin
                lex_mode = LX_HEX;
            end
        end else if (angle_wait == ANG_GT) begin
            angle_wait = ANG_NONE;
            put_byte(C_GT);
            if (c == C_GT) begin
                put_byte(C_GT);
                taken = 1'b1;
            end
            need_newline = 1'b1;
        end
        if (!taken)
            mode_char(c);
        if (eos) begin
            if (angle_wait == ANG_LT) begin
                put_newline();
                put_byte(C_LT);
            end else if (angle_wait == ANG_GT) begin
                put_byte(C_GT);
            end
            if (lex_mode inside {LX_NAME, LX_WORD, LX_NUM, LX_NUMSIGN})
                close_token();
            reset_lexer();
        end
        if (minified_run.size() == 0)
            add_run_word(t_mini_word'{8'h00, 1'b0, 1'b0, 1'b0});
        minified_run[minified_run.size() - 1].run_last = 1'b1;
        minified_run[minified_run.size() - 1].strm_end = eos;
    endfunction

    function automatic logic [7:0] pick_space();
        case ($urandom_range(5))
            0: return C_SP;
            1: return C_TAB;
            2: return C_CR;
            3: return C_LF;
            4: return C_VT;
            default: return C_FF;
        endcase
    endfunction

    // one stream of random tokens, mostly well formed
    function automatic void build_stream();
        int start, depth;
        logic [7:0] b;
        stream_bytes.delete();
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(11))
                2: begin
                    add_stream_byte(C_LPAR);
                    depth = 1;
                    repeat ($urandom_range(0, 6)) begin
                        case ($urandom_range(4))
                            0: add_stream_byte(8'($urandom_range(255)));
                            1: begin
                                add_stream_byte(C_BSLASH);
                                add_stream_byte(8'($urandom_range(255)));
                            end
                            2: begin
                                add_stream_byte(C_LPAR);
                                depth++;
                            end
                            3: begin
                                if (depth > 1) begin
                                    add_stream_byte(C_RPAR);
                                    depth--;
                                end
                            end
                            default: add_stream_byte(CH_A + 8'($urandom_range(25)));
                        endcase
                    end
                    if ($urandom_range(7) != 0)
                        repeat (depth) add_stream_byte(C_RPAR);
                end
                3: begin
                    add_stream_byte(C_LT);
                    repeat ($urandom_range(0, 6)) begin
                        if ($urandom_range(3) == 0)
                            add_stream_byte(pick_space());
                        else if ($urandom_range(1) != 0)
                            add_stream_byte(C_ZERO + 8'($urandom_range(9)));
                        else
                            add_stream_byte(CH_UA + 8'($urandom_range(5)));
                    end
                    if ($urandom_range(7) != 0)
                        add_stream_byte(C_GT);
                end
                4: begin
                    add_stream_byte(C_SLASH);
                    repeat ($urandom_range(0, 4))
                        add_stream_byte(CH_A + 8'($urandom_range(25)));
                end
                5: begin
                    repeat ($urandom_range(1, 3)) begin
                        if ($urandom_range(3) == 0)
                            add_stream_byte(CH_UA + 8'($urandom_range(25)));
                        else
                            add_stream_byte(CH_A + 8'($urandom_range(25)));
                    end
                    if ($urandom_range(3) == 0)
                        add_stream_byte(CH_STAR);
                end
                6: begin
                    add_stream_byte(C_PCT);
                    repeat ($urandom_range(0, 5)) begin
                        b = 8'($urandom_range(255));
                        if (b != C_LF)
                            add_stream_byte(b);
                    end
                    if ($urandom_range(7) != 0)
                        add_stream_byte(C_LF);
                end
                7: begin
                    b = ($urandom_range(1) != 0) ? C_LT : C_GT;
                    add_stream_byte(b);
                    add_stream_byte(b);
                end
                8: add_stream_byte(($urandom_range(1) != 0) ? C_LBRK : C_RBRK);
                9: add_stream_byte(($urandom_range(1) != 0) ? C_RPAR : C_GT);
                10: add_stream_byte(8'($urandom_range(255)));
                default: begin
                    // number: optional sign, integer part, fraction with trailing zeros
                    start = stream_bytes.size();
                    case ($urandom_range(2))
                        1: add_stream_byte(C_MINUS);
                        2: add_stream_byte(C_PLUS);
                        default: ;
                    endcase
                    case ($urandom_range(3))
                        1: add_stream_byte(C_ZERO);
                        2: repeat ($urandom_range(1, 3))
                            add_stream_byte(C_ZERO + 8'($urandom_range(9)));
                        3: begin
                            add_stream_byte(C_ZERO);
                            add_stream_byte(C_ZERO + 8'($urandom_range(9)));
                        end
                        default: ;
                    endcase
                    if ($urandom_range(2) != 0) begin
                        add_stream_byte(C_DOT);
                        repeat ($urandom_range(0, 2))
                            add_stream_byte(C_ZERO + 8'($urandom_range(9)));
                        repeat ($urandom_range(0, 4))
                            add_stream_byte(C_ZERO);
                    end
                    if (stream_bytes.size() == start)
                        add_stream_byte(C_ZERO + 8'($urandom_range(9)));
                end
            endcase
            if ($urandom_range(1) != 0)
                add_stream_byte(pick_space());
        end
    endfunction

    function automatic void note_mismatch(string what, t_mini_word want, t_mini_word got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%0t %0s: expected %02h/%0b/%0b/%0b, got %02h/%0b/%0b/%0b",
                     $realtime, what, want.data, want.is_byte, want.run_last, want.strm_end,
                     got.data, got.is_byte, got.run_last, got.strm_end);
    endfunction

    task automatic send_char(logic [7:0] c, logic eos, logic typed,
                             logic [7:0] t_byte, logic t_valid);
        // idle cycles follow a geometric gap so the idle share matches tx_idle_pct
        if ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        in_if.valid         <= 1'b1;
        in_if.in_byte       <= c;
        in_if.end_of_stream <= eos;
        do @(posedge clk); while (!in_if.ready);
        predict_minified(c, eos);
        if (typed)
            add_expected(t_mini_word'{t_byte, t_valid, 1'b1, eos});
        else
            foreach (minified_run[k]) add_expected(minified_run[k]);
    endtask

    task automatic send_stream();
        foreach (stream_bytes[i])
            send_char(stream_bytes[i], i == stream_bytes.size() - 1, 1'b0, 8'h00, 1'b0);
    endtask

    // sender stays quiet until every word has come back
    task automatic drain_output();
        in_if.valid <= 1'b0;
        do @(posedge clk); while (expected_words.size() != 0);
    endtask

    // output side: check, then choose ready for the next edge
    always @(posedge clk) begin
        t_mini_word got, want;
        if (rst_n && out_if.valid && out_if.ready) begin
            got = t_mini_word'{out_if.out_byte, out_if.byte_valid,
                               out_if.last_of_run, out_if.stream_end};
            if (expected_words.size() == 0) begin
                note_mismatch("unexpected word", '0, got);
            end else begin
                want = expected_words.pop_front();
                if (got !== want)
                    note_mismatch("wrong word", want, got);
            end
        end
        if (rx_hold_req != rx_hold_seen) begin
            rx_hold_seen = rx_hold_req;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (!rst_n) begin
            out_if.ready <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_content_stream_minifier failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int done;
        in_if.valid         = 1'b0;
        in_if.in_byte       = 8'h00;
        in_if.end_of_stream = 1'b0;
        reset_lexer();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_char(dir_rows[i].chr, dir_rows[i].eos, dir_rows[i].typed,
                      dir_rows[i].exp_byte, dir_rows[i].exp_valid);
        drain_output();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 66; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 66; end
                default: begin tx_idle_pct = 33; rx_stall_pct = 33; end
            endcase
            if (ph == 2) begin
                // held-zero cap: flush with dot and dropped leading zero, then again
                stream_bytes.delete();
                add_stream_byte(C_MINUS);
                add_stream_byte(C_ZERO);
                add_stream_byte(C_DOT);
                repeat (MAX_ZEROS + 1) add_stream_byte(C_ZERO);
                add_stream_byte(C_ZERO + 8'd7);
                repeat (MAX_ZEROS + 3) add_stream_byte(C_ZERO);
                send_stream();
            end
            done = 0;
            while (done < PHASE_ITEMS) begin
                build_stream();
                send_stream();
                done += stream_bytes.size();
            end
            drain_output();
        end

        // long receiver hold while a nested string keeps coming at full rate
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_req <= ~rx_hold_req;
        stream_bytes.delete();
        repeat (HOLD_NEST) add_stream_byte(C_LPAR);
        repeat (HOLD_NEST) add_stream_byte(C_RPAR);
        add_stream_byte(CH_UA + 8'd16);
        send_stream();
        drain_output();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && expected_words.size() == 0)
            $display("tb_content_stream_minifier passed");
        else
            $display("tb_content_stream_minifier failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/csm_pkg.sv
rtl/core/csm_in_if.sv
rtl/core/csm_out_if.sv
rtl/core/csm_front.sv
rtl/core/csm_queue.sv
rtl/core/csm_back.sv
rtl/core/content_stream_minifier.sv
rtl/core/csm_checker.sv
tb/tb_content_stream_minifier.sv
